// File: hdl/mcm_pkg.sv
// Shared types and constants for the movement conflict matrix.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package mcm_pkg;

  localparam int CMD_W       = 2;
  localparam int LANE_W      = 8;
  localparam int BEARING_W   = 9;
  localparam int MASK_W      = 64;
  localparam int MOVE_W      = 2 * LANE_W + 2 * BEARING_W;
  localparam int IN_TDATA_W  = ((MOVE_W + MASK_W + 7) / 8) * 8;
  localparam int IDX_OUT_W   = 6;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_CHECK = 2'd2
  } cmd_t;

  // src_id sits in the lowest bits, matching the request layout
  typedef struct packed {
    logic [BEARING_W-1:0] tgt_bearing;
    logic [LANE_W-1:0]    tgt_id;
    logic [BEARING_W-1:0] src_bearing;
    logic [LANE_W-1:0]    src_id;
  } movement_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic scan;
    logic write;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic scan_done;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hdl/mcm_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none

module mcm_ram #(
  parameter int WIDTH = 98,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/mcm_ctrl.sv
// Controller state machine: sequences dispatch, table scan, write-back and result.
// Depends on mcm_pkg.
`default_nettype none

module mcm_ctrl
  import mcm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_DISPATCH = 5'b00010,
    ST_SCAN     = 5'b00100,
    ST_WRITE    = 5'b01000,
    ST_FINISH   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status.cmd)
          CMD_ADD:   state_nxt = status.full ? ST_FINISH : ST_SCAN;
          CMD_CHECK: state_nxt = ST_SCAN;
          CMD_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = ST_FINISH;
          end
          default:   state_nxt = ST_FINISH;
        endcase
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = (status.cmd == CMD_ADD) ? ST_WRITE : ST_FINISH;
        end
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/mcm_dp.sv
// Datapath: request registers, movement table RAM, pairwise conflict test,
// phase check accumulator and result register. Depends on mcm_pkg and mcm_ram.
`default_nettype none

module mcm_dp
  import mcm_pkg::*;
#(
  parameter int MAX_MOVEMENTS = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [CMD_W-1:0]       in_tuser,
  input  wire ctrl_cmd_t              cmd,
  output dp_status_t                  status,
  output logic      [OUT_TDATA_W-1:0] out_tdata
);

  localparam int IDX_W   = $clog2(MAX_MOVEMENTS);
  localparam int CNT_W   = $clog2(MAX_MOVEMENTS + 1);
  localparam int ENTRY_W = MOVE_W + MAX_MOVEMENTS;

  // each table entry holds the movement and its conflicts with older entries
  cmd_t                     cmd_r;
  movement_t                move_r;
  logic [MAX_MOVEMENTS-1:0] mask_r;
  logic                     full_r;
  logic [IDX_OUT_W-1:0]     idx_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         ptr_r, ptr_nxt;
  logic                     vld_r;
  logic [IDX_W-1:0]         lane_r;
  logic [MAX_MOVEMENTS-1:0] row_acc_r;
  logic                     hit_r;
  logic [OUT_TDATA_W-1:0]   out_r;

  logic                     issue;
  logic [ENTRY_W-1:0]       rdata;
  movement_t                rd_move;
  logic [MAX_MOVEMENTS-1:0] rd_row;
  logic                     pair_conflict;
  logic                     res_safe;
  logic                     res_full;
  logic [IDX_OUT_W-1:0]     res_idx;

  function automatic logic conflicts(movement_t a, movement_t b);
    logic p0;
    logic p1;
    // A entries land on positions of equal parity exactly when owners alternate
    p0 = (a.tgt_bearing <  a.src_bearing) ^ (b.src_bearing < a.src_bearing)
       ^ (b.tgt_bearing <  a.src_bearing);
    p1 = (a.src_bearing <= a.tgt_bearing) ^ (b.src_bearing < a.tgt_bearing)
       ^ (b.tgt_bearing <  a.tgt_bearing);
    return (a.src_id != b.src_id) && (a.tgt_id != b.tgt_id) && (p0 == p1);
  endfunction

  mcm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_MOVEMENTS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (count_r[IDX_W-1:0]),
    .wdata ({row_acc_r, move_r}),
    .raddr (ptr_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign rd_move       = movement_t'(rdata[MOVE_W-1:0]);
  assign rd_row        = rdata[MOVE_W +: MAX_MOVEMENTS];
  assign pair_conflict = conflicts(rd_move, move_r);

  assign issue = cmd.scan && (ptr_r != count_r);

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.load) begin
      ptr_nxt = '0;
    end else if (issue) begin
      ptr_nxt = ptr_r + 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.write) begin
      count_nxt = count_r + 1'b1;
    end
  end

  assign status.cmd       = cmd_r;
  assign status.full      = full_r;
  assign status.scan_done = (ptr_r == count_r) && !vld_r;

  assign res_safe = (cmd_r == CMD_CHECK) && !hit_r;
  assign res_full = (cmd_r == CMD_ADD) && full_r;
  assign res_idx  = ((cmd_r == CMD_ADD) && !full_r) ? idx_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ptr_r   <= '0;
      vld_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      vld_r   <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= cmd_t'(in_tuser);
      move_r    <= movement_t'(in_tdata[MOVE_W-1:0]);
      mask_r    <= in_tdata[MOVE_W +: MAX_MOVEMENTS];
      full_r    <= (count_r >= CNT_W'(MAX_MOVEMENTS));
      idx_r     <= IDX_OUT_W'(count_r);
      row_acc_r <= '0;
      hit_r     <= 1'b0;
    end else if (vld_r) begin
      if (pair_conflict) begin
        row_acc_r[lane_r] <= 1'b1;
      end
      if (mask_r[lane_r] && (|(mask_r & rd_row))) begin
        hit_r <= 1'b1;
      end
    end
    lane_r <= ptr_r[IDX_W-1:0];
    if (cmd.publish) begin
      out_r <= {res_safe, res_full, res_idx};
    end
  end

  assign out_tdata = out_r;

endmodule

`default_nettype wire

// File: hdl/movement_conflict_matrix_core.sv
// Top level of the movement conflict matrix: controller plus datapath.
// Depends on mcm_pkg, mcm_ctrl, mcm_dp (and mcm_ram through mcm_dp).
//
// channel  dir  signals                     contents (low bit up)
// in_      in   tvalid tready tdata tuser   tdata: src_lane_id, src_bearing,
//                                           tgt_lane_id, tgt_bearing, green_mask
// out_     out  tvalid tready tdata         tdata: movement_index, table_full,
//                                           phase_safe
//
// An add walks the table RAM after dispatch and then writes its new entry; a check
// walks the table only. Both read one entry per cycle through the RAM's single read
// port. Clear, a refused add and other commands skip the scan and go straight to the
// result. Synchronous active-low reset empties the table at once; no clearing pass.
// A new request is taken while a result waits in the output register; a stalled
// output holds the block before its next result.
`default_nettype none

module movement_conflict_matrix_core
  import mcm_pkg::*;
#(
  parameter int MAX_MOVEMENTS = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // src_lane_id, src_bearing, tgt_lane_id, tgt_bearing, green_mask, zero pad
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd
  input  wire logic [CMD_W-1:0]       in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // movement_index, table_full, phase_safe
  output logic      [OUT_TDATA_W-1:0] out_tdata
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mcm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  mcm_dp #(
    .MAX_MOVEMENTS (MAX_MOVEMENTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

// File: hdl/mcm_checker.sv
// Port-level checks for the movement conflict matrix, bound to the top level.
// Depends on mcm_pkg and movement_conflict_matrix_core.
`default_nettype none

module mcm_checker
  import mcm_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  // results are cleared by reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

  // one request at a time: ready drops after each accepted request
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is at work");

  // a refused add and a safe check never report an index, nor set both flags
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[IDX_OUT_W] || out_tdata[IDX_OUT_W+1]) |->
      (out_tdata[IDX_OUT_W-1:0] == '0) &&
      !(out_tdata[IDX_OUT_W] && out_tdata[IDX_OUT_W+1]))
    else $error("inconsistent result fields");

endmodule

bind movement_conflict_matrix_core mcm_checker u_mcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: dv/tb_movement_conflict_matrix_core.sv
// Self-checking testbench for movement_conflict_matrix_core: directed and random requests,
// with a predictor of the movement table and conflict matrix and a result scoreboard.
// Depends on mcm_pkg and the core RTL only.
module tb_movement_conflict_matrix_core;
  import mcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_MOVES = 64;
  localparam int RANDOM_ITEMS = 500;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  typedef struct packed {
    logic                 safe;
    logic                 full;
    logic [IDX_OUT_W-1:0] idx;
  } mcm_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // predictor state: mirror of the movement table and conflict matrix
  movement_t        table_moves [MAX_MOVES];
  logic [MASK_W-1:0] conflict_map [MAX_MOVES];
  int unsigned      table_count = 0;

  mcm_result_t pending_results[$];
  mcm_result_t got_result;
  mcm_result_t want_result;
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned stall_cycles = 0;
  bit          steady = 1'b0;

  movement_conflict_matrix_core #(
    .MAX_MOVEMENTS(MAX_MOVES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stable sort of the four bearings, tagged by owner; crossing paths alternate owners.
  function automatic bit bearings_alternate(movement_t stored, movement_t incoming);
    logic [BEARING_W-1:0] key [4];
    bit                   owner [4];
    logic [BEARING_W-1:0] k;
    bit                   o;
    int                   j;
    key[0] = stored.src_bearing;   owner[0] = 1'b0;
    key[1] = stored.tgt_bearing;   owner[1] = 1'b0;
    key[2] = incoming.src_bearing; owner[2] = 1'b1;
    key[3] = incoming.tgt_bearing; owner[3] = 1'b1;
    for (int i = 1; i < 4; i++) begin
      k = key[i];
      o = owner[i];
      j = i;
      while (j > 0 && key[j-1] > k) begin
        key[j] = key[j-1];
        owner[j] = owner[j-1];
        j--;
      end
      key[j] = k;
      owner[j] = o;
    end
    return owner[0] != owner[1] && owner[1] != owner[2];
  endfunction

  function automatic bit movements_cross(movement_t stored, movement_t incoming);
    if (stored.src_id == incoming.src_id || stored.tgt_id == incoming.tgt_id) return 1'b0;
    return bearings_alternate(stored, incoming);
  endfunction

  // Apply one request to the mirror and return the result it must produce.
  function automatic mcm_result_t apply_request(logic [CMD_W-1:0] op, movement_t mv,
                                                logic [MASK_W-1:0] mask);
    mcm_result_t r;
    int unsigned slot;
    r = '0;
    case (op)
      CMD_ADD: begin
        if (table_count >= MAX_MOVES) begin
          r.full = 1'b1;
        end else begin
          slot = table_count;
          for (int i = 0; i < slot; i++) begin
            if (movements_cross(table_moves[i], mv)) begin
              conflict_map[i][slot] = 1'b1;
              conflict_map[slot][i] = 1'b1;
            end
          end
          table_moves[slot] = mv;
          table_count = slot + 1;
          r.idx = slot[IDX_OUT_W-1:0];
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < MAX_MOVES; i++) conflict_map[i] = '0;
        table_count = 0;
      end
      CMD_CHECK: begin
        r.safe = 1'b1;
        for (int i = 0; i < table_count; i++) begin
          if (mask[i] && |(mask & conflict_map[i])) r.safe = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] op, input movement_t mv,
                              input logic [MASK_W-1:0] mask);
    int unsigned gap;
    mcm_result_t expected;
    if (!steady && $urandom_range(99) < 20) begin
      gap = ($urandom_range(7) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 4);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W - MOVE_W - MASK_W){1'b0}}, mask, mv};
    do @(posedge clk); while (!in_tready);
    expected = apply_request(op, mv, mask);
    pending_results.insert(pending_results.size(), expected);
    items_sent++;
  endtask

  function automatic movement_t make_move(logic [LANE_W-1:0] sid, logic [BEARING_W-1:0] sb,
                                          logic [LANE_W-1:0] tid, logic [BEARING_W-1:0] tb);
    movement_t m;
    m.src_id = sid;
    m.src_bearing = sb;
    m.tgt_id = tid;
    m.tgt_bearing = tb;
    return m;
  endfunction

  function automatic logic [BEARING_W-1:0] rand_bearing();
    case ($urandom_range(7))
      0:       return BEARING_W'($urandom_range(511));
      1, 2:    return BEARING_W'(90 * $urandom_range(3));
      default: return BEARING_W'($urandom_range(359));
    endcase
  endfunction

  // A small lane pool makes shared source or target lanes common.
  function automatic movement_t rand_move(int unsigned pool);
    logic [LANE_W-1:0] sid, tid;
    sid = (pool == 0) ? LANE_W'($urandom) : LANE_W'($urandom_range(pool - 1));
    tid = (pool == 0) ? LANE_W'($urandom) : LANE_W'($urandom_range(pool - 1));
    return make_move(sid, rand_bearing(), tid, rand_bearing());
  endfunction

  function automatic logic [MASK_W-1:0] rand_mask();
    int unsigned a, b;
    case ($urandom_range(6))
      0: return {$urandom, $urandom};
      1: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      2, 3: begin
        if (table_count < 2) return {$urandom, $urandom};
        a = $urandom_range(table_count - 1);
        b = $urandom_range(table_count - 1);
        return (64'd1 << a) | (64'd1 << b);
      end
      4: return '1;
      5: return '0;
      default: return 64'd1 << $urandom_range(63);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_result = mcm_result_t'(out_tdata);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, out_tdata", out_tdata, 0);
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.idx != want_result.idx)
          report_mismatch("movement_index", got_result.idx, want_result.idx);
        if (got_result.full != want_result.full)
          report_mismatch("table_full", got_result.full, want_result.full);
        if (got_result.safe != want_result.safe)
          report_mismatch("phase_safe", got_result.safe, want_result.safe);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_empty_table();
    send_request(CMD_CHECK, rand_move(0), '1);
    send_request(CMD_RESERVED, rand_move(0), rand_mask());
    send_request(CMD_CLEAR, rand_move(0), rand_mask());
    send_request(CMD_CHECK, rand_move(0), '0);
  endtask

  task automatic test_directed();
    send_request(CMD_CLEAR, '0, '0);
    send_request(CMD_ADD, make_move(8'd1, 9'd10, 8'd2, 9'd100), '0);
    // paths cross: bearings interleave
    send_request(CMD_ADD, make_move(8'd3, 9'd50, 8'd4, 9'd200), '0);
    send_request(CMD_CHECK, '0, 64'h3);
    send_request(CMD_CHECK, '0, 64'h1);
    // shares the source lane with the first movement
    send_request(CMD_ADD, make_move(8'd1, 9'd50, 8'd5, 9'd200), '0);
    // shares the target lane with the second movement
    send_request(CMD_ADD, make_move(8'd6, 9'd0, 8'd4, 9'd511), '0);
    send_request(CMD_ADD, make_move(8'd255, 9'd511, 8'd255, 9'd511), '1);
    send_request(CMD_ADD, make_move(8'd0, 9'd0, 8'd0, 9'd0), '0);
    // equal bearings resolve by stable order
    send_request(CMD_ADD, make_move(8'd7, 9'd90, 8'd8, 9'd270), '0);
    send_request(CMD_ADD, make_move(8'd9, 9'd90, 8'd10, 9'd180), '0);
    send_request(CMD_ADD, make_move(8'd11, 9'd270, 8'd12, 9'd90), '0);
    send_request(CMD_CHECK, '0, '1);
    // only bits of unused slots, from the stored count up
    send_request(CMD_CHECK, '0, ~((64'd1 << table_count) - 64'd1));
    send_request(CMD_CHECK, '0, '0);
    send_request(CMD_CHECK, '0, 64'd1 << 63);
    send_request(CMD_RESERVED, '1, '1);
    send_request(CMD_CHECK, '1, 64'h0000_0000_0000_0FFF);
    send_request(CMD_CLEAR, '1, '1);
    send_request(CMD_CHECK, '0, '1);
  endtask

  // Run without any idling on either side while the table fills up.
  task automatic test_full_table();
    steady = 1'b1;
    send_request(CMD_CLEAR, rand_move(0), '0);
    repeat (MAX_MOVES) send_request(CMD_ADD, rand_move(24), rand_mask());
    repeat (2) send_request(CMD_ADD, rand_move(0), rand_mask());
    send_request(CMD_CHECK, rand_move(0), '1);
    repeat (4) send_request(CMD_CHECK, rand_move(0), rand_mask());
    send_request(CMD_CLEAR, rand_move(0), '0);
    steady = 1'b0;
  endtask

  task automatic test_random_sessions();
    int unsigned pool;
    int unsigned adds;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(3) != 0) send_request(CMD_CLEAR, rand_move(0), rand_mask());
      pool = ($urandom_range(2) == 0) ? 0 : $urandom_range(2, 16);
      adds = ($urandom_range(9) == 0) ? $urandom_range(40, 66) : $urandom_range(1, 12);
      repeat (adds) begin
        send_request(CMD_ADD, rand_move(pool), rand_mask());
        if ($urandom_range(4) == 0) send_request(CMD_CHECK, rand_move(0), rand_mask());
      end
      repeat ($urandom_range(1, 4)) send_request(CMD_CHECK, rand_move(0), rand_mask());
      if ($urandom_range(9) == 0) send_request(CMD_RESERVED, rand_move(0), rand_mask());
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_MOVES; i++) begin
      table_moves[i] = '0;
      conflict_map[i] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_directed();
    test_full_table();
    test_random_sessions();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/mcm_pkg.sv
hdl/mcm_ram.sv
hdl/mcm_ctrl.sv
hdl/mcm_dp.sv
hdl/movement_conflict_matrix_core.sv
hdl/mcm_checker.sv
dv/tb_movement_conflict_matrix_core.sv
